// ===== design/fcf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcf_pkg: shared types and constants for the circular FIR filter
// Field widths, item opcodes and the control bundle that drives the cell row.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int unsigned DATA_W = 16;  // sample and coefficient width
  localparam int unsigned ACC_W  = 32;  // wrapped sum width
  localparam int unsigned IDX_W  = 5;   // coefficient slot width
  localparam int unsigned TAP_W  = 6;   // tap count register width

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic clear;   // zero the sample held in each cell
    logic shift;   // insert a new sample, older samples move one cell down
    logic rotate;  // pass sample and coefficient to the neighbor cell
    logic load;    // write a coefficient into the cell whose slot matches
  } fcf_ctrl_t;

endpackage
`default_nettype wire

// ===== design/fcf_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcf_cell: one tap of the filter
// Holds one delayed sample and one coefficient, shifts and rotates them.
// ----------------------------------------------------------------------------
module fcf_cell
  import fcf_pkg::*;
#(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fcf_ctrl_t                ctl_i,
  input  wire logic [IDX_W-1:0]         ld_index_i,
  input  wire logic signed [DATA_W-1:0] ld_value_i,
  input  wire logic signed [DATA_W-1:0] samp_prev_i,
  input  wire logic signed [DATA_W-1:0] samp_next_i,
  input  wire logic signed [DATA_W-1:0] coef_next_i,
  output logic signed [DATA_W-1:0]      samp_o,
  output logic signed [DATA_W-1:0]      coef_o
);

  logic signed [DATA_W-1:0] samp_q;
  logic signed [DATA_W-1:0] coef_q;
  logic                     hit;

  assign hit = (32'(ld_index_i) == CellIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q <= '0;
      coef_q <= '0;
    end else begin
      priority if (ctl_i.clear) begin
        samp_q <= '0;
      end else if (ctl_i.shift) begin
        samp_q <= samp_prev_i;
      end else if (ctl_i.rotate) begin
        samp_q <= samp_next_i;
      end else begin
        samp_q <= samp_q;
      end
      priority if (ctl_i.load && hit) begin
        coef_q <= ld_value_i;
      end else if (ctl_i.rotate) begin
        coef_q <= coef_next_i;
      end else begin
        coef_q <= coef_q;
      end
    end
  end

  assign samp_o = samp_q;
  assign coef_o = coef_q;

endmodule
`default_nettype wire

// ===== design/fcf_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fcf_mac: multiply-accumulate unit
// Registers one product per cycle and adds it into a wrapping accumulator when step_i and use_i were both set.
// ----------------------------------------------------------------------------
module fcf_mac
  import fcf_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clear_i,
  input  wire logic                     step_i,
  input  wire logic                     use_i,
  input  wire logic signed [DATA_W-1:0] coef_i,
  input  wire logic signed [DATA_W-1:0] samp_i,
  output logic [ACC_W-1:0]              acc_o
);

  localparam int unsigned ProdW = 2 * DATA_W;

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_v_q;
  logic [ACC_W-1:0]        acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= step_i && use_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(coef_i) * ProdW'(samp_i);
    if (clear_i) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      // wrap on overflow
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ===== design/fir_filter_circular_16.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_circular_16: FIR filter over a row of tap cells
// Filters signed 16-bit samples with up to MAX_TAPS stored coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries opcode_i, coeff_index_i
//   and value_i. A load item (opcode 1) writes one coefficient and gives no
//   result; slots at or above MAX_TAPS are dropped. A sample item (opcode 0)
//   enters the newest-sample cell, then the row rotates MAX_TAPS times past
//   the multiply-accumulate unit, one tap per cycle; taps at or above the
//   tap count are skipped. The wrapped 32-bit sum passes the last and done
//   states and is then written to the output register on filter_out_o. The
//   input stalls while a sample is in work, so no new sample is taken before
//   the last sum has left the done state.
//   Output channel (out_valid_o / out_stall_i): the result sits in an output
//   register, so the next item is taken while it waits. If a new sum finishes
//   before the old one is taken, hold the sum and keep stalling the input.
//   Config channel (cfg_valid_i / cfg_ready_o) writes tap_count; a write
//   clears all delayed samples. Tap count zero acts as one, above MAX_TAPS
//   as MAX_TAPS.
//   Reset clears coefficients and samples and sets tap count to one.
// ----------------------------------------------------------------------------
module fir_filter_circular_16
  import fcf_pkg::*;
#(
  parameter int unsigned MAX_TAPS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [0:0]               opcode_i,
  input  wire logic [IDX_W-1:0]         coeff_index_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [ACC_W-1:0]       filter_out_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [TAP_W-1:0]         cfg_data_i
);

  localparam int unsigned CntW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned NW   = $clog2(MAX_TAPS + 1) + 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_TAPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TAP_W-1:0] tap_q;
  logic [NW-1:0]    taps;
  logic             in_acc, cfg_acc, out_free;
  logic             out_valid_q;
  logic [ACC_W-1:0] out_data_q;
  logic [ACC_W-1:0] acc;
  fcf_ctrl_t        ctl;

  logic signed [DATA_W-1:0] samp [MAX_TAPS];
  logic signed [DATA_W-1:0] coef [MAX_TAPS];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Taps in use: zero acts as one, saturate at the built size
  always_comb begin
    taps = NW'(tap_q);
    if (tap_q == '0) begin
      taps = NW'(1);
    end else if (32'(tap_q) > MAX_TAPS) begin
      taps = NW'(MAX_TAPS);
    end
  end

  always_comb begin
    ctl.clear  = cfg_acc;
    ctl.shift  = in_acc && (opcode_i == OP_SAMPLE);
    ctl.load   = in_acc && (opcode_i == OP_LOAD);
    ctl.rotate = (state_q == ST_RUN);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctl.shift) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastCnt) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tap_q       <= TAP_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_acc) begin
        tap_q <= cfg_data_i;
      end
      // Advance the finished sum into the output register when it is free
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= acc;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filter_out_o = out_data_q;

  // Row of tap cells: shift toward higher index, rotate toward lower index
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    localparam int unsigned Nxt = (i + 1) % MAX_TAPS;
    localparam int unsigned Prv = (i == 0) ? 0 : i - 1;
    logic signed [DATA_W-1:0] samp_prev;

    assign samp_prev = (i == 0) ? value_i : samp[Prv];

    fcf_cell #(
      .CellIdx (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .ld_index_i  (coeff_index_i),
      .ld_value_i  (value_i),
      .samp_prev_i (samp_prev),
      .samp_next_i (samp[Nxt]),
      .coef_next_i (coef[Nxt]),
      .samp_o      (samp[i]),
      .coef_o      (coef[i])
    );
  end

  // Cell 0 holds tap cnt_q while the row rotates
  fcf_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ctl.shift),
    .step_i  (state_q == ST_RUN),
    .use_i   (NW'(cnt_q) < taps),
    .coef_i  (coef[0]),
    .samp_i  (samp[0]),
    .acc_o   (acc)
  );

  a_last_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LAST |=> state_q == ST_DONE)
    else $error("final product not followed by done");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == LastCnt) |=> state_q == ST_LAST)
    else $error("rotation did not end after the last tap");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised without a finished sum");

  a_no_rotate_on_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !ctl.rotate)
    else $error("item accepted while the row rotates");

endmodule
`default_nettype wire
